@@ hw/rtl/bba_pkg.sv @@
// Shared types and codes of the bitmap block allocator.
package bba_pkg;

  localparam int unsigned RESV_W = 11;
  localparam int unsigned GRANT_W = 10;

  localparam logic [1:0] FUNC_ALLOC  = 2'd0;
  localparam logic [1:0] FUNC_FREE   = 2'd1;
  localparam logic [1:0] FUNC_FORMAT = 2'd2;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] block_index;
  } in_t;

  typedef struct packed {
    logic [GRANT_W-1:0] granted_block;
    logic [1:0]         status;
  } out_t;

endpackage

@@ hw/rtl/bitmap_block_allocator_core.sv @@
// First-fit bitmap block allocator: free map in RAM, per-word summary and valid bits in flops.
// Each item gives one result. An allocate or an in-range free goes from acceptance to the
// result register through accept, RAM read, read-modify-write and result push; the RAM read
// step is needed as the free-map RAM has registered read data. A format, an out-of-range free,
// a full-map allocate and an unused code go straight to the result push. A result waiting on
// out_stall_i delays the next acceptance. A format completes in one step: per-word valid bits
// are cleared and words not yet rewritten read back as the format pattern, so no clearing pass
// is needed after reset or format. WORD_BITS must be a power of two.
module bitmap_block_allocator_core
  import bba_pkg::*;
#(
  parameter int unsigned NUM_BLOCKS = 1024,
  parameter int unsigned WORD_BITS  = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  in_t               in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output out_t              out_data_o,
  input  logic              cfg_we_i,
  input  logic [RESV_W-1:0] cfg_wdata_i
);

  localparam int unsigned MAP_WORDS = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned LOG_WB    = $clog2(WORD_BITS);
  localparam int unsigned AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int unsigned CNT_W     = $clog2(NUM_BLOCKS + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_MOD,
    S_PUSH
  } state_e;

  state_e                 state_q;
  logic [MAP_WORDS-1:0]   sum_q;
  logic [MAP_WORDS-1:0]   valid_q;
  logic [CNT_W-1:0]       fmt_n_q;
  logic [CNT_W-1:0]       fmt_n_d;
  logic [RESV_W-1:0]      resv_q;
  logic [AW-1:0]          addr_q;
  logic [LOG_WB-1:0]      bit_q;
  logic [1:0]             op_q;
  out_t                   res_q;
  out_t                   out_q;
  logic                   out_valid_q;

  logic [WORD_BITS-1:0]   rdata;
  logic [WORD_BITS-1:0]   fmt_word;
  logic [WORD_BITS-1:0]   vmask;
  logic [WORD_BITS-1:0]   word_eff;
  logic [WORD_BITS-1:0]   new_word;
  logic [LOG_WB-1:0]      low_bit;
  logic [AW-1:0]          first_w;
  logic [MAP_WORDS-1:0]   fmt_sum;
  logic [31:0]            n_cap;
  logic [16:0]            blk_ext;
  logic                   blk_oor;
  logic [31:0]            gidx;
  logic                   accept;
  logic                   slot_free;

  bba_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MAP_WORDS),
    .AW    (AW)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (state_q == S_MOD),
    .waddr_i (addr_q),
    .wdata_i (new_word),
    .raddr_i (addr_q),
    .rdata_o (rdata)
  );

  assign accept    = in_valid_i && (state_q == S_IDLE);
  assign slot_free = !out_valid_q || !out_stall_i;
  assign blk_ext   = {1'b0, in_data_i.block_index};
  assign blk_oor   = blk_ext >= 17'(NUM_BLOCKS);
  assign n_cap     = (32'(resv_q) > 32'(NUM_BLOCKS)) ? 32'(NUM_BLOCKS) : 32'(resv_q);
  assign fmt_n_d   = CNT_W'(n_cap);

  always_comb begin
    logic [31:0] base;
    base = 32'(addr_q) << LOG_WB;
    for (int b = 0; b < int'(WORD_BITS); b++) begin
      fmt_word[b] = (base + 32'(b)) >= 32'(fmt_n_q);
      vmask[b]    = (base + 32'(b)) < 32'(NUM_BLOCKS);
    end
    word_eff = (valid_q[addr_q] ? rdata : fmt_word) & vmask;
  end

  always_comb begin
    low_bit = '0;
    for (int b = int'(WORD_BITS) - 1; b >= 0; b--) begin
      if (word_eff[b]) begin
        low_bit = LOG_WB'(b);
      end
    end
  end

  always_comb begin
    first_w = '0;
    for (int w = int'(MAP_WORDS) - 1; w >= 0; w--) begin
      if (sum_q[w]) begin
        first_w = AW'(w);
      end
    end
  end

  always_comb begin
    int unsigned lim;
    for (int w = 0; w < int'(MAP_WORDS); w++) begin
      lim = (32'(w) + 32'd1) * WORD_BITS;
      if (lim > NUM_BLOCKS) begin
        lim = NUM_BLOCKS;
      end
      fmt_sum[w] = n_cap < 32'(lim);
    end
  end

  always_comb begin
    if (op_q == FUNC_ALLOC) begin
      new_word = word_eff & ~(WORD_BITS'(1) << low_bit);
    end else begin
      new_word = word_eff | (WORD_BITS'(1) << bit_q);
    end
  end

  assign gidx = (32'(addr_q) << LOG_WB) | 32'(low_bit);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sum_q       <= '1;
      valid_q     <= '0;
      fmt_n_q     <= '0;
      resv_q      <= RESV_W'(4);
      out_valid_q <= 1'b0;
      op_q        <= FUNC_ALLOC;
    end else begin
      if (cfg_we_i) begin
        resv_q <= cfg_wdata_i;
      end
      if (out_valid_q && !out_stall_i && state_q != S_PUSH) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            op_q <= in_data_i.func;
            case (in_data_i.func)
              FUNC_ALLOC: begin
                if (sum_q == '0) begin
                  res_q   <= '{granted_block: '0, status: ST_FULL};
                  state_q <= S_PUSH;
                end else begin
                  res_q   <= '{granted_block: '0, status: ST_DONE};
                  addr_q  <= first_w;
                  state_q <= S_READ;
                end
              end
              FUNC_FREE: begin
                if (blk_oor) begin
                  res_q   <= '{granted_block: '0, status: ST_RANGE};
                  state_q <= S_PUSH;
                end else begin
                  res_q   <= '{granted_block: '0, status: ST_DONE};
                  addr_q  <= blk_ext[LOG_WB +: AW];
                  bit_q   <= in_data_i.block_index[LOG_WB-1:0];
                  state_q <= S_READ;
                end
              end
              FUNC_FORMAT: begin
                res_q   <= '{granted_block: '0, status: ST_DONE};
                valid_q <= '0;
                fmt_n_q <= fmt_n_d;
                sum_q   <= fmt_sum;
                state_q <= S_PUSH;
              end
              default: begin
                res_q   <= '{granted_block: '0, status: ST_DONE};
                state_q <= S_PUSH;
              end
            endcase
          end
        end
        S_READ: begin
          state_q <= S_MOD;
        end
        S_MOD: begin
          valid_q[addr_q] <= 1'b1;
          sum_q[addr_q]   <= |new_word;
          if (op_q == FUNC_ALLOC) begin
            res_q.granted_block <= gidx[GRANT_W-1:0];
          end
          state_q <= S_PUSH;
        end
        S_PUSH: begin
          if (slot_free) begin
            out_valid_q <= 1'b1;
            out_q       <= res_q;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_alloc_word_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MOD && op_q == FUNC_ALLOC) |-> (sum_q[addr_q] && |word_eff))
    else $error("allocate reached a word without a free block");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q != S_IDLE))
    else $error("accepted item did not start work");

  a_result_from_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_PUSH))
    else $error("result loaded outside push step");

  a_full_grants_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status != ST_DONE) |-> (out_data_o.granted_block == '0))
    else $error("failed item carries a block index");

endmodule

@@ hw/rtl/bba_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module bba_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ tb/bitmap_block_allocator_core_tb.sv @@
// Testbench for the first-fit bitmap block allocator, with a free-map predictor and random traffic.
`timescale 1ns / 1ps

module bitmap_block_allocator_core_tb;
  import bba_pkg::*;

  localparam int unsigned NUM_BLOCKS = 1024;
  localparam int unsigned WORD_BITS  = 32;
  localparam logic [1:0]  FUNC_UNUSED = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned PHASE_ITEMS = 240;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned HOLD_AT_ITEM = 380;

  typedef enum bit {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e         kind;
    logic [RESV_W-1:0] resv;
    logic [1:0]        func;
    logic [15:0]       blk;
    bit                typed;
    logic [GRANT_W-1:0] grant;
    logic [1:0]        status;
  } row_t;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  in_t               in_data;
  logic              out_valid;
  logic              out_stall;
  out_t              out_data;
  logic              cfg_we;
  logic [RESV_W-1:0] cfg_wdata;

  bit [NUM_BLOCKS-1:0] free_blocks;
  logic [RESV_W-1:0]   resv_count;
  out_t                replies_due[$];
  int unsigned         accepted;
  int unsigned         mismatches;
  int unsigned         cycles;
  int unsigned         burst_left;

  row_t dir_rows [0:26] = '{
    '{ROW_ITEM, 11'd0,    FUNC_ALLOC,  16'd0,     1'b1, 10'd0,    ST_DONE},
    '{ROW_ITEM, 11'd0,    FUNC_ALLOC,  16'd0,     1'b1, 10'd1,    ST_DONE},
    '{ROW_ITEM, 11'd0,    FUNC_FREE,   16'd1023,  1'b1, 10'd0,    ST_DONE},
    '{ROW_ITEM, 11'd0,    FUNC_FREE,   16'd1024,  1'b1, 10'd0,    ST_RANGE},
    '{ROW_ITEM, 11'd0,    FUNC_FREE,   16'hFFFF,  1'b1, 10'd0,    ST_RANGE},
    '{ROW_ITEM, 11'd0,    FUNC_UNUSED, 16'hFFFF,  1'b1, 10'd0,    ST_DONE},
    '{ROW_ITEM, 11'd0,    FUNC_FORMAT, 16'hFFFF,  1'b1, 10'd0,    ST_DONE},
    '{ROW_ITEM, 11'd0,    FUNC_ALLOC,  16'hFFFF,  1'b1, 10'd4,    ST_DONE},
    '{ROW_ITEM, 11'd0,    FUNC_FREE,   16'd2,     1'b1, 10'd0,    ST_DONE},
    '{ROW_ITEM, 11'd0,    FUNC_ALLOC,  16'd0,     1'b1, 10'd2,    ST_DONE},
    '{ROW_ITEM, 11'd0,    FUNC_ALLOC,  16'h5A5A,  1'b0, 10'd0,    ST_DONE},
    '{ROW_CFG,  11'd2047, FUNC_ALLOC,  16'd0,     1'b0, 10'd0,    ST_DONE},
    '{ROW_ITEM, 11'd0,    FUNC_FORMAT, 16'd0,     1'b1, 10'd0,    ST_DONE},
    '{ROW_ITEM, 11'd0,    FUNC_ALLOC,  16'd0,     1'b1, 10'd0,    ST_FULL},
    '{ROW_ITEM, 11'd0,    FUNC_FREE,   16'd1023,  1'b1, 10'd0,    ST_DONE},
    '{ROW_ITEM, 11'd0,    FUNC_ALLOC,  16'd0,     1'b1, 10'd1023, ST_DONE},
    '{ROW_ITEM, 11'd0,    FUNC_ALLOC,  16'd0,     1'b1, 10'd0,    ST_FULL},
    '{ROW_ITEM, 11'd0,    FUNC_FREE,   16'd32,    1'b1, 10'd0,    ST_DONE},
    '{ROW_ITEM, 11'd0,    FUNC_FREE,   16'd31,    1'b1, 10'd0,    ST_DONE},
    '{ROW_ITEM, 11'd0,    FUNC_ALLOC,  16'd0,     1'b0, 10'd0,    ST_DONE},
    '{ROW_ITEM, 11'd0,    FUNC_ALLOC,  16'd0,     1'b0, 10'd0,    ST_DONE},
    '{ROW_CFG,  11'd1024, FUNC_ALLOC,  16'd0,     1'b0, 10'd0,    ST_DONE},
    '{ROW_ITEM, 11'd0,    FUNC_FORMAT, 16'd0,     1'b1, 10'd0,    ST_DONE},
    '{ROW_ITEM, 11'd0,    FUNC_ALLOC,  16'd0,     1'b1, 10'd0,    ST_FULL},
    '{ROW_CFG,  11'd0,    FUNC_ALLOC,  16'd0,     1'b0, 10'd0,    ST_DONE},
    '{ROW_ITEM, 11'd0,    FUNC_FORMAT, 16'd0,     1'b1, 10'd0,    ST_DONE},
    '{ROW_ITEM, 11'd0,    FUNC_ALLOC,  16'd0,     1'b1, 10'd0,    ST_DONE}
  };

  bitmap_block_allocator_core #(
    .NUM_BLOCKS(NUM_BLOCKS),
    .WORD_BITS (WORD_BITS)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic out_t apply_request(in_t req);
    out_t res;
    int   hit;
    res = '0;
    res.status = ST_DONE;
    case (req.func)
      FUNC_ALLOC: begin
        hit = -1;
        for (int b = 0; b < NUM_BLOCKS; b++) begin
          if (free_blocks[b] && hit < 0) hit = b;
        end
        if (hit < 0) begin
          res.status = ST_FULL;
        end else begin
          free_blocks[hit] = 1'b0;
          res.granted_block = GRANT_W'(hit);
        end
      end
      FUNC_FREE: begin
        if (req.block_index >= NUM_BLOCKS) res.status = ST_RANGE;
        else free_blocks[req.block_index] = 1'b1;
      end
      FUNC_FORMAT: begin
        for (int b = 0; b < NUM_BLOCKS; b++) free_blocks[b] = (b >= resv_count);
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic in_t random_request();
    in_t req;
    int  pick;
    pick = $urandom_range(99);
    req.block_index = 16'($urandom);
    if (pick < 55) begin
      req.func = FUNC_ALLOC;
    end else if (pick < 92) begin
      req.func = FUNC_FREE;
      pick = $urandom_range(99);
      if (pick < 40) req.block_index = 16'($urandom_range(0, 127));
      else if (pick < 85) req.block_index = 16'($urandom_range(0, NUM_BLOCKS - 1));
    end else if (pick < 96) begin
      req.func = FUNC_FORMAT;
    end else begin
      req.func = FUNC_UNUSED;
    end
    return req;
  endfunction

  task automatic report_mismatch(string msg);
    mismatches++;
    if (mismatches <= 100) $display("%0t mismatch: %s", $time, msg);
  endtask

  task automatic send_item(in_t req, bit typed, out_t want);
    out_t predicted;
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall);
    predicted = apply_request(req);
    replies_due.push_back(typed ? want : predicted);
    accepted++;
  endtask

  task automatic pace_sender();
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
  endtask

  task automatic write_reserve(logic [RESV_W-1:0] value);
    in_valid <= 1'b0;
    @(posedge clk);
    while (replies_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    resv_count = value;
  endtask

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (replies_due.size() == 0) begin
        report_mismatch($sformatf("unexpected result grant=%0d status=%0d",
                                  out_data.granted_block, out_data.status));
      end else begin
        want = replies_due.pop_front();
        if (out_data.granted_block !== want.granted_block)
          report_mismatch($sformatf("granted_block got %0d want %0d",
                                    out_data.granted_block, want.granted_block));
        if (out_data.status !== want.status)
          report_mismatch($sformatf("status got %0d want %0d",
                                    out_data.status, want.status));
      end
    end
  end

  initial begin
    bit          hold_done;
    int unsigned pct;
    int unsigned left;
    hold_done = 1'b0;
    pct = 0;
    left = 0;
    out_stall <= 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (!hold_done && accepted >= HOLD_AT_ITEM) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        if (left == 0) begin
          left = $urandom_range(16, 96);
          case ($urandom_range(3))
            0: pct = 0;
            1: pct = 20;
            2: pct = 50;
            default: pct = 85;
          endcase
        end
        left--;
        out_stall <= ($urandom_range(99) < pct);
      end
    end
  end

  initial begin
    logic [RESV_W-1:0] phase_resv [8];
    in_t               req;
    out_t              want;
    phase_resv = '{11'd2047, 11'd1024, 11'd1023, 11'd0, 11'd1000, 11'd31, 11'd32, 11'd0};
    phase_resv[7] = RESV_W'($urandom_range(0, 2047));
    in_valid   <= 1'b0;
    in_data    <= '0;
    cfg_we     <= 1'b0;
    cfg_wdata  <= '0;
    rst_n      <= 1'b0;
    free_blocks = '1;
    resv_count  = 11'd4;
    accepted    = 0;
    mismatches  = 0;
    cycles      = 0;
    burst_left  = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        write_reserve(dir_rows[i].resv);
      end else begin
        req.func          = dir_rows[i].func;
        req.block_index   = dir_rows[i].blk;
        want.granted_block = dir_rows[i].grant;
        want.status        = dir_rows[i].status;
        send_item(req, dir_rows[i].typed, want);
        pace_sender();
      end
    end

    for (int p = 0; p < 8; p++) begin
      write_reserve(phase_resv[p]);
      req = '0;
      req.func = FUNC_FORMAT;
      req.block_index = 16'($urandom);
      send_item(req, 1'b0, '0);
      pace_sender();
      for (int n = 1; n < PHASE_ITEMS; n++) begin
        send_item(random_request(), 1'b0, '0);
        pace_sender();
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (replies_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES * 2) @(posedge clk);
    if (replies_due.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", replies_due.size()));
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/bba_pkg.sv
hw/rtl/bba_ram.sv
hw/rtl/bitmap_block_allocator_core.sv
tb/bitmap_block_allocator_core_tb.sv
